// ===== hw/rtl/aaid_pkg.sv =====
package aaid_pkg;

	localparam int COL_LIMIT    = 4096;
	localparam int ROW_LIMIT    = 4096;
	localparam int MAX_CHANNELS = 4;

	localparam int DIM_W  = 13;                      // size registers
	localparam int CNT_W  = 12;                      // counters and phases
	localparam int COL_W  = $clog2(COL_LIMIT);       // store address
	localparam int CH_W   = $clog2(MAX_CHANNELS);    // channel index
	localparam int SUM_W  = 32;
	localparam int AREA_W = 25;
	localparam int NUM_W  = 40;                      // divider dividend
	localparam int DCNT_W = $clog2(NUM_W + 1);

	localparam logic [DIM_W-1:0] MAX_W_C  = DIM_W'(COL_LIMIT);
	localparam logic [DIM_W-1:0] MAX_H_C  = DIM_W'(ROW_LIMIT);
	localparam logic [2:0]       MAX_CH_C = 3'(MAX_CHANNELS);

	// register indexes
	localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
	localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
	localparam logic [2:0] REG_CHANNELS   = 3'd4;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [AREA_W-1:0] area;
	} acc_t;

	typedef struct packed {
		acc_t [MAX_CHANNELS-1:0] ch;
	} ent_t;

endpackage

// ===== hw/rtl/area_average_image_downscale.sv =====
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid / in_ready     | sample0..sample3
// out     | output    | out_valid / out_ready   | pixel0..pixel3, result_col, result_row
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pixel is in work at a time. Each touched store column costs a read-modify-write;
// with four channels every weight adds a byte-wise divide by 255 (no digit steps when
// the weight is zero), and an emitting pixel adds up to four bit-serial divisions for
// sum / area. Two store columns are touched at most.
// After reset all 4096 store columns are cleared with in_ready low; cfg is always ready.
// A pending out word does not block input; the block stalls only when a new result is
// ready while the previous one is still waiting.
module area_average_image_downscale
	import aaid_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       sample0,
	input  logic [7:0]       sample1,
	input  logic [7:0]       sample2,
	input  logic [7:0]       sample3,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       pixel0,
	output logic [7:0]       pixel1,
	output logic [7:0]       pixel2,
	output logic [7:0]       pixel3,
	output logic [CNT_W-1:0] result_col,
	output logic [CNT_W-1:0] result_row,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_LOAD, S_MUL1, S_MUL2, S_AREA,
		S_PM, S_PD, S_D255, S_DIV, S_ACC, S_EMIT, S_EQ, S_WR
	} state_t;

	typedef enum logic [1:0] {R_AREA, R_SUM, R_EMIT} ret_t;

	state_t state_q;
	ret_t   ret_q;

	// configuration
	logic [DIM_W-1:0] in_width_q, in_height_q, out_width_q, out_height_q;
	logic [2:0]       channels_q;

	// frame position
	logic [CNT_W-1:0] in_col_q, in_row_q, col_ph_q, row_ph_q, out_col_q, out_row_q;

	// per pixel
	logic [7:0]       smp_q [MAX_CHANNELS];
	logic [DIM_W-1:0] fx_q [2];
	logic [DIM_W-1:0] fr_q [2];
	logic [COL_W-1:0] wx_q, col_q;
	logic [CNT_W-1:0] orow_q;
	logic [2:0]       ch_q;
	logic             alpha_q, emit_q, j_q, r_q;
	logic [CH_W-1:0]  c_q;
	logic [COL_W-1:0] clr_q;

	ent_t             ent_q [2];
	logic [AREA_W-1:0] ov_q, a_q;
	logic [SUM_W-1:0]  w_q, s_q;
	logic [NUM_W-1:0]  prod_q;
	logic [7:0]        q_q [MAX_CHANNELS];

	// divider
	logic [NUM_W-1:0]  dv_num_q;
	logic [AREA_W-1:0] dv_den_q, dv_rem_q;
	logic [DCNT_W-1:0] dv_cnt_q;

	// output register
	logic              out_valid_q;
	logic [7:0]        pix_q [MAX_CHANNELS];
	logic [CNT_W-1:0]  res_col_q, res_row_q;

	// stores
	ent_t cur_mem [COL_LIMIT];
	ent_t nxt_mem [COL_LIMIT];
	ent_t cur_rd, nxt_rd, cur_wd, nxt_wd;
	logic mem_re, mem_we;
	logic [COL_W-1:0] mem_addr;

	// geometry
	logic [DIM_W-1:0] iw, ih, ow, oh;
	logic [2:0]       chn;
	logic [CNT_W-1:0] ic, cp, oc, ir, rp, orow;
	logic [DIM_W:0]   cs_raw, rs_raw, cs_sub, rs_sub;
	logic             end_col, end_row;
	logic [CNT_W-1:0] cs, rs;
	logic [DIM_W-1:0] fcc, fcn, frc, frn;
	logic [DIM_W-1:0] ic_n, ir_n;

	logic             accept, emit_now, wr_go, wt, ch_skip;
	logic [7:0]       v;
	logic [SUM_W-1:0] pm_op;
	logic [AREA_W:0]  dv_t, dv_d;
	logic             dv_ge;
	logic [15:0]      d8_t, d8_s, d8_r;
	logic [7:0]       d8_q;
	logic [NUM_W-1:0] emit_num;
	logic [AREA_W-1:0] emit_area;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	assign out_valid  = out_valid_q;
	assign pixel0     = pix_q[0];
	assign pixel1     = pix_q[1];
	assign pixel2     = pix_q[2];
	assign pixel3     = pix_q[3];
	assign result_col = res_col_q;
	assign result_row = res_row_q;

	always_comb begin
		iw = (in_width_q == '0) ? DIM_W'(1) : (in_width_q > MAX_W_C) ? MAX_W_C : in_width_q;
		ih = (in_height_q == '0) ? DIM_W'(1) : (in_height_q > MAX_H_C) ? MAX_H_C : in_height_q;
		ow = (out_width_q == '0) ? DIM_W'(1) : (out_width_q > iw) ? iw : out_width_q;
		oh = (out_height_q == '0) ? DIM_W'(1) : (out_height_q > ih) ? ih : out_height_q;
		chn = (channels_q == '0) ? 3'd1 : (channels_q > MAX_CH_C) ? MAX_CH_C : channels_q;

		// stale positions read as zero
		ic   = ({1'b0, in_col_q}  >= iw) ? '0 : in_col_q;
		cp   = ({1'b0, col_ph_q}  >= iw) ? '0 : col_ph_q;
		oc   = ({1'b0, out_col_q} >= ow) ? '0 : out_col_q;
		ir   = ({1'b0, in_row_q}  >= ih) ? '0 : in_row_q;
		rp   = ({1'b0, row_ph_q}  >= ih) ? '0 : row_ph_q;
		orow = ({1'b0, out_row_q} >= oh) ? '0 : out_row_q;

		cs_raw  = {2'b0, cp} + {1'b0, ow};
		end_col = cs_raw >= {1'b0, iw};
		cs_sub  = cs_raw - {1'b0, iw};
		cs      = end_col ? cs_sub[CNT_W-1:0] : cs_raw[CNT_W-1:0];
		fcc     = end_col ? ow - {1'b0, cs} : ow;
		fcn     = end_col ? {1'b0, cs} : '0;

		rs_raw  = {2'b0, rp} + {1'b0, oh};
		end_row = rs_raw >= {1'b0, ih};
		rs_sub  = rs_raw - {1'b0, ih};
		rs      = end_row ? rs_sub[CNT_W-1:0] : rs_raw[CNT_W-1:0];
		frc     = end_row ? oh - {1'b0, rs} : oh;
		frn     = end_row ? {1'b0, rs} : '0;

		ic_n = {1'b0, ic} + DIM_W'(1);
		ir_n = {1'b0, ir} + DIM_W'(1);
	end

	always_comb begin
		emit_now  = emit_q && !j_q;
		wr_go     = !emit_now || !out_valid_q || out_ready;
		wt        = alpha_q && (c_q != CH_W'(MAX_CHANNELS - 1));
		ch_skip   = {1'b0, c_q} >= ch_q;
		v         = smp_q[c_q];
		pm_op     = wt ? w_q : SUM_W'(ov_q);
		dv_t      = {dv_rem_q, dv_num_q[NUM_W-1]};
		dv_d      = {1'b0, dv_den_q};
		dv_ge     = dv_t >= dv_d;
		// one base-256 digit of x / 255: remainder below 255 keeps the digit exact
		d8_t      = {dv_rem_q[7:0], dv_num_q[NUM_W-1 -: 8]};
		d8_s      = d8_t + 16'd1 + {8'b0, d8_t[15:8]};
		d8_q      = d8_s[15:8];
		d8_r      = d8_t - {d8_q, 8'b0} + {8'b0, d8_q};
		emit_area = ent_q[0].ch[c_q].area;
		emit_num  = NUM_W'(ent_q[0].ch[c_q].sum) + NUM_W'(emit_area[AREA_W-1:1]);

		mem_re   = (state_q == S_RD);
		mem_we   = (state_q == S_CLR) || (state_q == S_WR && wr_go);
		mem_addr = (state_q == S_CLR) ? clr_q : col_q;
		if (state_q == S_CLR) begin
			cur_wd = '0;
			nxt_wd = '0;
		end else if (emit_now) begin
			// the next-row column moves up and starts over empty
			cur_wd = ent_q[1];
			nxt_wd = '0;
		end else begin
			cur_wd = ent_q[0];
			nxt_wd = ent_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cur_mem[mem_addr] <= cur_wd;
			nxt_mem[mem_addr] <= nxt_wd;
		end
		if (mem_re) begin
			cur_rd <= cur_mem[mem_addr];
			nxt_rd <= nxt_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= DIM_W'(1);
			in_height_q  <= DIM_W'(1);
			out_width_q  <= DIM_W'(1);
			out_height_q <= DIM_W'(1);
			channels_q   <= MAX_CH_C;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IN_WIDTH:   in_width_q   <= cfg_data;
				REG_IN_HEIGHT:  in_height_q  <= cfg_data;
				REG_OUT_WIDTH:  out_width_q  <= cfg_data;
				REG_OUT_HEIGHT: out_height_q <= cfg_data;
				REG_CHANNELS:   channels_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ret_q       <= R_AREA;
			clr_q       <= '0;
			in_col_q    <= '0;
			in_row_q    <= '0;
			col_ph_q    <= '0;
			row_ph_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_valid_q <= 1'b0;
			j_q         <= 1'b0;
			r_q         <= 1'b0;
			c_q         <= '0;
			dv_cnt_q    <= '0;
		end else begin
			if (state_q == S_WR && wr_go && emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + COL_W'(1);
					if (clr_q == COL_W'(COL_LIMIT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						smp_q[0] <= sample0;
						smp_q[1] <= sample1;
						smp_q[2] <= sample2;
						smp_q[3] <= sample3;
						fx_q[0]  <= fcc;
						fx_q[1]  <= fcn;
						fr_q[0]  <= frc;
						fr_q[1]  <= frn;
						wx_q     <= oc;
						col_q    <= oc;
						orow_q   <= orow;
						ch_q     <= chn;
						alpha_q  <= (chn == MAX_CH_C);
						emit_q   <= end_row && end_col;
						j_q      <= 1'b0;
						state_q  <= S_RD;
						// advance the frame position
						if (ic_n >= iw) begin
							in_col_q  <= '0;
							col_ph_q  <= '0;
							out_col_q <= '0;
							if (ir_n >= ih) begin
								in_row_q  <= '0;
								row_ph_q  <= '0;
								out_row_q <= '0;
							end else begin
								in_row_q  <= ir_n[CNT_W-1:0];
								row_ph_q  <= rs;
								out_row_q <= end_row ? orow + CNT_W'(1) : orow;
							end
						end else begin
							in_col_q  <= ic_n[CNT_W-1:0];
							col_ph_q  <= cs;
							out_col_q <= end_col ? oc + CNT_W'(1) : oc;
							in_row_q  <= ir;
							row_ph_q  <= rp;
							out_row_q <= orow;
						end
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					ent_q[0] <= cur_rd;
					ent_q[1] <= nxt_rd;
					r_q      <= 1'b0;
					state_q  <= S_MUL1;
				end
				S_MUL1: begin
					ov_q    <= AREA_W'(fx_q[j_q] * fr_q[r_q]);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					w_q     <= SUM_W'(ov_q * smp_q[MAX_CHANNELS-1]);
					state_q <= S_AREA;
				end
				S_AREA: begin
					c_q <= '0;
					if (alpha_q) begin
						dv_num_q <= NUM_W'(w_q);
						dv_rem_q <= '0;
						dv_cnt_q <= (w_q == '0) ? '0 : DCNT_W'(NUM_W / 8);
						ret_q    <= R_AREA;
						state_q  <= S_D255;
					end else begin
						a_q     <= ov_q;
						state_q <= S_PM;
					end
				end
				S_PM: begin
					if (ch_skip) begin
						if (!r_q) begin
							r_q     <= 1'b1;
							state_q <= S_MUL1;
						end else if (emit_now) begin
							c_q     <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_WR;
						end
					end else begin
						prod_q  <= NUM_W'(v * pm_op);
						state_q <= S_PD;
					end
				end
				S_PD: begin
					if (wt) begin
						dv_num_q <= prod_q;
						dv_rem_q <= '0;
						dv_cnt_q <= (prod_q == '0) ? '0 : DCNT_W'(NUM_W / 8);
						ret_q    <= R_SUM;
						state_q  <= S_D255;
					end else begin
						s_q     <= prod_q[SUM_W-1:0];
						state_q <= S_ACC;
					end
				end
				S_D255: begin
					if (dv_cnt_q != '0) begin
						dv_rem_q <= AREA_W'(d8_r[7:0]);
						dv_num_q <= {dv_num_q[NUM_W-9:0], d8_q};
						dv_cnt_q <= dv_cnt_q - DCNT_W'(1);
					end else if (ret_q == R_AREA) begin
						a_q     <= dv_num_q[AREA_W-1:0];
						state_q <= S_PM;
					end else begin
						s_q     <= dv_num_q[SUM_W-1:0];
						state_q <= S_ACC;
					end
				end
				S_DIV: begin
					if (dv_cnt_q != '0) begin
						dv_rem_q <= dv_ge ? AREA_W'(dv_t - dv_d) : dv_t[AREA_W-1:0];
						dv_num_q <= {dv_num_q[NUM_W-2:0], dv_ge};
						dv_cnt_q <= dv_cnt_q - DCNT_W'(1);
					end else begin
						unique case (ret_q)
							R_AREA: begin
								a_q     <= dv_num_q[AREA_W-1:0];
								state_q <= S_PM;
							end
							R_SUM: begin
								s_q     <= dv_num_q[SUM_W-1:0];
								state_q <= S_ACC;
							end
							R_EMIT: begin
								state_q <= S_EQ;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ACC: begin
					ent_q[r_q].ch[c_q].sum  <= ent_q[r_q].ch[c_q].sum + s_q;
					ent_q[r_q].ch[c_q].area <= ent_q[r_q].ch[c_q].area + (wt ? a_q : ov_q);
					if (c_q != CH_W'(MAX_CHANNELS - 1)) begin
						c_q     <= c_q + CH_W'(1);
						state_q <= S_PM;
					end else if (!r_q) begin
						r_q     <= 1'b1;
						state_q <= S_MUL1;
					end else if (emit_now) begin
						c_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WR;
					end
				end
				S_EMIT: begin
					if (!ch_skip && emit_area != '0) begin
						dv_num_q <= emit_num;
						dv_den_q <= emit_area;
						dv_rem_q <= '0;
						dv_cnt_q <= (emit_num == '0) ? '0 : DCNT_W'(NUM_W);
						ret_q    <= R_EMIT;
						state_q  <= S_DIV;
					end else begin
						q_q[c_q] <= '0;
						if (c_q == CH_W'(MAX_CHANNELS - 1)) begin
							state_q <= S_WR;
						end else begin
							c_q <= c_q + CH_W'(1);
						end
					end
				end
				S_EQ: begin
					q_q[c_q] <= (dv_num_q[NUM_W-1:8] != '0) ? 8'hFF : dv_num_q[7:0];
					if (c_q == CH_W'(MAX_CHANNELS - 1)) begin
						state_q <= S_WR;
					end else begin
						c_q     <= c_q + CH_W'(1);
						state_q <= S_EMIT;
					end
				end
				S_WR: begin
					if (wr_go) begin
						if (emit_now) begin
							pix_q       <= q_q;
							res_col_q   <= wx_q;
							res_row_q   <= orow_q;
						end
						// second column only when the pixel straddles a boundary
						if (!j_q && fx_q[1] != '0 && wx_q != COL_W'(COL_LIMIT - 1)) begin
							j_q     <= 1'b1;
							col_q   <= wx_q + COL_W'(1);
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_input_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !in_ready)
		else $error("input taken during store clear");

	a_out_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && emit_now && wr_go) |-> (!out_valid_q || out_ready))
		else $error("pending out word overwritten");

	a_div_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (dv_rem_q < dv_den_q))
		else $error("divider remainder not below divisor");

	a_second_col_straddles: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD && j_q) |-> (fx_q[1] != '0 && col_q == wx_q + COL_W'(1)))
		else $error("second column read without a straddle");

endmodule
